// File: hdl/ir_remote_frame_decoder_defines.svh
// Assertion macros shared by the infrared frame decoder RTL.
// No dependencies; each using module provides clk and rst_n.
`ifndef IR_REMOTE_FRAME_DECODER_DEFINES_SVH
`define IR_REMOTE_FRAME_DECODER_DEFINES_SVH

// Condition that holds at every clock edge out of reset.
`define IRFD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define IRFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/irfd_pkg.sv
// Types, constants and the command table of the infrared frame decoder.
// No dependencies.
package irfd_pkg;

    localparam int unsigned IV_W       = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned FRAME_BITS = 32;
    localparam int unsigned CNT_W      = $clog2(FRAME_BITS);
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = IV_W;

    localparam logic [CFG_DATA_W-1:0] LEADER_THRESHOLD_RST = 16'd13631;
    localparam logic [CFG_DATA_W-1:0] ONE_THRESHOLD_RST    = 16'd1600;

    localparam logic [CFG_IDX_W-1:0] CFG_LEADER_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_THRESHOLD    = 2'd1;

    localparam logic [BYTE_W-1:0] CMD_CH_MINUS = 8'hA2;
    localparam logic [BYTE_W-1:0] CMD_CH       = 8'h62;
    localparam logic [BYTE_W-1:0] CMD_CH_PLUS  = 8'hE2;
    localparam logic [BYTE_W-1:0] CMD_PREV     = 8'h22;
    localparam logic [BYTE_W-1:0] CMD_NEXT     = 8'h02;

    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(FRAME_BITS - 1);

    typedef enum logic [2:0] {
        BTN_CH_MINUS = 3'd0,
        BTN_CH       = 3'd1,
        BTN_CH_PLUS  = 3'd2,
        BTN_PREV     = 3'd3,
        BTN_NEXT     = 3'd4,
        BTN_UNKNOWN  = 3'd5
    } button_t;

    typedef enum logic {
        ST_IDLE    = 1'b0,
        ST_RECEIVE = 1'b1
    } frame_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] address_inverse;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] command_inverse;
        button_t           button;
        logic              led_red;
        logic              led_green;
    } result_t;

    function automatic button_t button_of(input logic [BYTE_W-1:0] cmd);
        button_t btn;
        case (cmd)
            CMD_CH_MINUS: btn = BTN_CH_MINUS;
            CMD_CH:       btn = BTN_CH;
            CMD_CH_PLUS:  btn = BTN_CH_PLUS;
            CMD_PREV:     btn = BTN_PREV;
            CMD_NEXT:     btn = BTN_NEXT;
            default:      btn = BTN_UNKNOWN;
        endcase
        return btn;
    endfunction

endpackage

// File: hdl/irfd_if.sv
// Valid/ready channel interfaces of the infrared frame decoder.
// Depends on irfd_pkg.
interface irfd_in_if;
    logic                        valid;
    logic                        ready;
    logic [irfd_pkg::IV_W-1:0]   interval;

    modport source (output valid, output interval, input ready);
    modport sink   (input valid, input interval, output ready);
endinterface

interface irfd_out_if;
    logic                          valid;
    logic                          ready;
    logic [irfd_pkg::BYTE_W-1:0]   address;
    logic [irfd_pkg::BYTE_W-1:0]   address_inverse;
    logic [irfd_pkg::BYTE_W-1:0]   command;
    logic [irfd_pkg::BYTE_W-1:0]   command_inverse;
    logic [2:0]                    button;
    logic                          led_red;
    logic                          led_green;

    modport source (output valid, output address, output address_inverse,
                    output command, output command_inverse, output button,
                    output led_red, output led_green, input ready);
    modport sink   (input valid, input address, input address_inverse,
                    input command, input command_inverse, input button,
                    input led_red, input led_green, output ready);
endinterface

// File: hdl/irfd_frame.sv
// Frame receiver: leader detect, bit classify, shift, button and LED update.
// Depends on irfd_pkg, irfd_if and the assertion macro header.
`include "ir_remote_frame_decoder_defines.svh"

module irfd_frame (
    input  logic                              clk,
    input  logic                              rst_n,
    irfd_in_if.sink                           in_ch,
    input  logic                              buf_ready,
    input  logic [irfd_pkg::CFG_DATA_W-1:0]   leader_threshold,
    input  logic [irfd_pkg::CFG_DATA_W-1:0]   one_threshold,
    output logic                              res_valid,
    output irfd_pkg::result_t                 res
);

    irfd_pkg::frame_state_t                state_reg, state_next;
    logic [irfd_pkg::CNT_W-1:0]            bit_count_reg, bit_count_next;
    logic [irfd_pkg::FRAME_BITS-1:0]       shift_reg, shift_next;
    logic                                  red_reg, red_next;
    logic                                  green_reg, green_next;

    logic                                  fire;
    logic                                  is_one;
    logic [irfd_pkg::FRAME_BITS-1:0]       shifted;
    irfd_pkg::button_t                     btn;

    assign in_ch.ready = buf_ready;
    assign fire        = in_ch.valid && buf_ready;
    assign is_one      = in_ch.interval > one_threshold;
    assign shifted     = {shift_reg[irfd_pkg::FRAME_BITS-2:0], is_one};
    assign btn         = irfd_pkg::button_of(shifted[15:8]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= irfd_pkg::ST_IDLE;
            bit_count_reg <= '0;
            shift_reg     <= '0;
            red_reg       <= 1'b1;
            green_reg     <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            red_reg       <= red_next;
            green_reg     <= green_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        res_valid      = 1'b0;

        case (state_reg)
            irfd_pkg::ST_IDLE:
            begin
                if (fire && (in_ch.interval > leader_threshold))
                begin
                    state_next     = irfd_pkg::ST_RECEIVE;
                    bit_count_next = '0;
                    shift_next     = '0;
                end
            end
            irfd_pkg::ST_RECEIVE:
            begin
                if (fire)
                begin
                    shift_next     = shifted;
                    bit_count_next = bit_count_reg + 1'b1;
                    if (bit_count_reg == irfd_pkg::LAST_BIT)
                    begin
                        state_next     = irfd_pkg::ST_IDLE;
                        bit_count_next = '0;
                        res_valid      = 1'b1;
                        case (btn)
                            irfd_pkg::BTN_CH_MINUS:
                            begin
                                red_next   = 1'b1;
                                green_next = 1'b1;
                            end
                            irfd_pkg::BTN_CH:
                            begin
                                red_next   = 1'b0;
                                green_next = 1'b0;
                            end
                            irfd_pkg::BTN_CH_PLUS:
                            begin
                                red_next   = 1'b0;
                                green_next = 1'b1;
                            end
                            irfd_pkg::BTN_PREV:
                            begin
                                red_next   = 1'b1;
                                green_next = 1'b0;
                            end
                            default:
                            begin
                                red_next   = red_reg;
                                green_next = green_reg;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = irfd_pkg::ST_IDLE;
            end
        endcase
    end

    assign res.address         = shifted[31:24];
    assign res.address_inverse = shifted[23:16];
    assign res.command         = shifted[15:8];
    assign res.command_inverse = shifted[7:0];
    assign res.button          = btn;
    assign res.led_red         = red_next;
    assign res.led_green       = green_next;

    `IRFD_ASSERT_ALWAYS(a_res_only_receiving,
        !res_valid || (state_reg == irfd_pkg::ST_RECEIVE), "result outside a frame")
    `IRFD_ASSERT_NEXT(a_idle_after_res, res_valid,
        (state_reg == irfd_pkg::ST_IDLE) && (bit_count_reg == '0), "no return to idle")
    `IRFD_ASSERT_ALWAYS(a_idle_count_zero,
        (state_reg != irfd_pkg::ST_IDLE) || (bit_count_reg == '0), "count nonzero in idle")

endmodule

// File: hdl/irfd_out_buf.sv
// Two-entry result buffer (output register plus skid entry) on the out channel.
// Depends on irfd_pkg, irfd_if and the assertion macro header.
`include "ir_remote_frame_decoder_defines.svh"

module irfd_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  irfd_pkg::result_t   push_data,
    output logic                buf_ready,
    irfd_out_if.source          out_ch
);

    logic                out_valid_reg, out_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    irfd_pkg::result_t   out_data_reg, out_data_next;
    irfd_pkg::result_t   skid_data_reg, skid_data_next;
    logic                pop;

    assign pop       = out_valid_reg && out_ch.ready;
    assign buf_ready = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (push)
        begin
            if (!out_valid_next)
            begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.address         = out_data_reg.address;
    assign out_ch.address_inverse = out_data_reg.address_inverse;
    assign out_ch.command         = out_data_reg.command;
    assign out_ch.command_inverse = out_data_reg.command_inverse;
    assign out_ch.button          = out_data_reg.button;
    assign out_ch.led_red         = out_data_reg.led_red;
    assign out_ch.led_green       = out_data_reg.led_green;

    `IRFD_ASSERT_ALWAYS(a_skid_needs_out,
        !skid_valid_reg || out_valid_reg, "skid entry without output entry")
    `IRFD_ASSERT_ALWAYS(a_no_push_full,
        !push || !skid_valid_reg, "item pushed into full buffer")
    `IRFD_ASSERT_NEXT(a_stall_keeps, out_valid_reg && !out_ch.ready,
        out_valid_reg, "stalled item dropped")

endmodule

// File: hdl/ir_remote_frame_decoder.sv
// Top level of the infrared remote frame decoder: config registers and wiring.
// Depends on irfd_pkg, irfd_if, irfd_frame and irfd_out_buf.
//
//   channel    dir  payload                                   handshake
//   intervals  in   interval[15:0]                            valid/ready
//   frames     out  address, address_inverse, command,        valid/ready
//                   command_inverse, button[2:0], leds
//   cfg_*      in   cfg_index[1:0], cfg_data[15:0]            cfg_we, no wait
//
// One interval item per cycle while intervals.ready is high; irfd_frame
// compares and shifts each one combinationally. Results are registered in
// a two-entry output buffer driving frames, which keeps input flowing while
// a result is stalled; intervals.ready drops only when both entries are full.
// Reset clears frame state, sets both LEDs on and loads default thresholds.
module ir_remote_frame_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    irfd_in_if.sink                           intervals,
    irfd_out_if.source                        frames,
    input  logic                              cfg_we,
    input  logic [irfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [irfd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [irfd_pkg::CFG_DATA_W-1:0]   leader_threshold_reg;
    logic [irfd_pkg::CFG_DATA_W-1:0]   one_threshold_reg;
    logic                              buf_ready;
    logic                              res_valid;
    irfd_pkg::result_t                 res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leader_threshold_reg <= irfd_pkg::LEADER_THRESHOLD_RST;
            one_threshold_reg    <= irfd_pkg::ONE_THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                irfd_pkg::CFG_LEADER_THRESHOLD: leader_threshold_reg <= cfg_data;
                irfd_pkg::CFG_ONE_THRESHOLD:    one_threshold_reg    <= cfg_data;
                default:
                begin
                    leader_threshold_reg <= leader_threshold_reg;
                end
            endcase
        end
    end

    irfd_frame u_frame (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_ch            (intervals),
        .buf_ready        (buf_ready),
        .leader_threshold (leader_threshold_reg),
        .one_threshold    (one_threshold_reg),
        .res_valid        (res_valid),
        .res              (res)
    );

    irfd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .buf_ready (buf_ready),
        .out_ch    (frames)
    );

endmodule

// File: tb/ir_remote_frame_decoder_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for ir_remote_frame_decoder: interval items in, decoded frames out.
// Depends on irfd_pkg, irfd_if and the decoder RTL; a built-in frame predictor checks results.
module ir_remote_frame_decoder_tb;
    import irfd_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_TARGET  = 150;
    localparam int NUM_PHASES    = 9;
    localparam int PRINT_LIMIT   = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum logic [1:0] {
        IV_IGNORED,
        IV_LEADER,
        IV_BIT,
        IV_FRAME
    } interval_use_t;

    typedef struct packed {
        logic [IV_W-1:0]       leader_thr;
        logic [IV_W-1:0]       one_thr;
        frame_state_t          mode;
        logic [CNT_W-1:0]      bits_in;
        logic [FRAME_BITS-1:0] word;
        logic                  red;
        logic                  green;
    } decoder_state_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    irfd_in_if  in_ch();
    irfd_out_if out_ch();

    logic [IV_W-1:0] interval_queue[$];
    result_t         expected_frames[$];
    decoder_state_t  pred_state;
    decoder_state_t  gen_state;

    int cycle_count;
    int mismatch_count;
    int frames_checked;
    int intervals_sent;
    int settings_applied;
    int phase_used;
    int burst_left;
    int gap_left;
    int stall_left;
    int stall_mode;
    int mode_left;

    ir_remote_frame_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .intervals (in_ch),
        .frames    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("ir_remote_frame_decoder test failed");
        $finish;
    end

    // Advances a decoder state by one interval; fills frame on the 32nd bit.
    function automatic interval_use_t decode_interval(inout decoder_state_t s,
                                                      input logic [IV_W-1:0] iv,
                                                      output result_t frame);
        button_t btn;
        frame = '0;
        if (s.mode == ST_IDLE)
        begin
            if (iv > s.leader_thr)
            begin
                s.mode    = ST_RECEIVE;
                s.bits_in = '0;
                s.word    = '0;
                return IV_LEADER;
            end
            return IV_IGNORED;
        end
        s.word = {s.word[FRAME_BITS-2:0], iv > s.one_thr};
        if (s.bits_in != LAST_BIT)
        begin
            s.bits_in = s.bits_in + 1'b1;
            return IV_BIT;
        end
        s.mode    = ST_IDLE;
        s.bits_in = '0;
        case (s.word[15:8])
            CMD_CH_MINUS: btn = BTN_CH_MINUS;
            CMD_CH:       btn = BTN_CH;
            CMD_CH_PLUS:  btn = BTN_CH_PLUS;
            CMD_PREV:     btn = BTN_PREV;
            CMD_NEXT:     btn = BTN_NEXT;
            default:      btn = BTN_UNKNOWN;
        endcase
        case (btn)
            BTN_CH_MINUS:
            begin
                s.red   = 1'b1;
                s.green = 1'b1;
            end
            BTN_CH:
            begin
                s.red   = 1'b0;
                s.green = 1'b0;
            end
            BTN_CH_PLUS:
            begin
                s.red   = 1'b0;
                s.green = 1'b1;
            end
            BTN_PREV:
            begin
                s.red   = 1'b1;
                s.green = 1'b0;
            end
            default: ;
        endcase
        frame.address         = s.word[31:24];
        frame.address_inverse = s.word[23:16];
        frame.command         = s.word[15:8];
        frame.command_inverse = s.word[7:0];
        frame.button          = btn;
        frame.led_red         = s.red;
        frame.led_green       = s.green;
        return IV_FRAME;
    endfunction

    function automatic void queue_interval(input logic [IV_W-1:0] iv);
        result_t unused_frame;
        interval_queue.push_back(iv);
        if (decode_interval(gen_state, iv, unused_frame) != IV_IGNORED)
            phase_used++;
    endfunction

    function automatic logic [IV_W-1:0] bit_interval(input logic one, input bit edgy);
        int thr;
        thr = int'(gen_state.one_thr);
        if (one && thr < 65535)
        begin
            if (edgy)
                return ($urandom_range(0, 1) == 0) ? IV_W'(thr + 1) : IV_W'(65535);
            return IV_W'($urandom_range(thr + 1, 65535));
        end
        if (edgy)
            return ($urandom_range(0, 1) == 0) ? IV_W'(thr) : IV_W'(0);
        return IV_W'($urandom_range(0, thr));
    endfunction

    function automatic logic [IV_W-1:0] leader_interval(input bit edgy);
        int thr;
        thr = int'(gen_state.leader_thr);
        if (edgy)
            return ($urandom_range(0, 1) == 0) ? IV_W'(thr + 1) : IV_W'(65535);
        return IV_W'($urandom_range(thr + 1, 65535));
    endfunction

    // Unless leader_thr is all ones: ends any open frame, sends idle noise, then a leader.
    function automatic bit open_frame(input bit edgy);
        if (gen_state.leader_thr == '1)
            return 1'b0;
        while (gen_state.mode == ST_RECEIVE)
            queue_interval(bit_interval(1'($urandom_range(0, 1)), 1'b0));
        repeat ($urandom_range(0, 2))
            queue_interval(IV_W'($urandom_range(0, int'(gen_state.leader_thr))));
        queue_interval(leader_interval(edgy));
        return 1'b1;
    endfunction

    function automatic void queue_frame(input logic [FRAME_BITS-1:0] word, input bit edgy);
        if (open_frame(edgy))
            for (int i = FRAME_BITS - 1; i >= 0; i--)
                queue_interval(bit_interval(word[i], edgy));
    endfunction

    // Cut-off frame; the tail is a leader-length interval that lands inside the frame.
    function automatic void queue_broken(input int nbits, input bit tail);
        if (open_frame(1'b0))
        begin
            repeat (nbits)
                queue_interval(bit_interval(1'($urandom_range(0, 1)), 1'b0));
            if (tail)
                queue_interval(leader_interval(1'b0));
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_LEADER_THRESHOLD: pred_state.leader_thr = data;
            CFG_ONE_THRESHOLD:    pred_state.one_thr = data;
            default: ;
        endcase
    endtask

    task automatic apply_thresholds(input logic [IV_W-1:0] leader, input logic [IV_W-1:0] one,
                                    input bit spare);
        write_reg(CFG_LEADER_THRESHOLD, leader);
        write_reg(CFG_ONE_THRESHOLD, one);
        if (spare)
        begin
            write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
            write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        gen_state = pred_state;
        settings_applied++;
    endtask

    task automatic drain;
        while (interval_queue.size() != 0 || in_ch.valid)
            @(negedge clk);
        while (expected_frames.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0d] frame %0d %s: got %02h, expected %02h",
                     cycle_count, frames_checked, what, got, want);
    endtask

    // Sender: bursts of random length, random gaps between them.
    always @(posedge clk or negedge rst_n)
    begin : interval_driver
        result_t frame;
        if (!rst_n)
        begin
            in_ch.valid    <= 1'b0;
            in_ch.interval <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                intervals_sent++;
                if (decode_interval(pred_state, in_ch.interval, frame) == IV_FRAME)
                    expected_frames.push_back(frame);
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end
                else if (interval_queue.size() != 0)
                begin
                    in_ch.valid    <= 1'b1;
                    in_ch.interval <= interval_queue.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each frame item and stalls in changing modes.
    always @(posedge clk or negedge rst_n)
    begin : frame_monitor
        result_t want;
        logic    ready_next;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
            stall_mode = 0;
            mode_left  = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_frames.size() == 0)
                    flag_mismatch("item with no frame pending", out_ch.command, '0);
                else
                begin
                    want = expected_frames.pop_front();
                    if (out_ch.address !== want.address)
                        flag_mismatch("address", out_ch.address, want.address);
                    if (out_ch.address_inverse !== want.address_inverse)
                        flag_mismatch("address_inverse", out_ch.address_inverse,
                                      want.address_inverse);
                    if (out_ch.command !== want.command)
                        flag_mismatch("command", out_ch.command, want.command);
                    if (out_ch.command_inverse !== want.command_inverse)
                        flag_mismatch("command_inverse", out_ch.command_inverse,
                                      want.command_inverse);
                    if (out_ch.button !== want.button)
                        flag_mismatch("button", {5'b0, out_ch.button}, {5'b0, want.button});
                    if (out_ch.led_red !== want.led_red)
                        flag_mismatch("led_red", {7'b0, out_ch.led_red}, {7'b0, want.led_red});
                    if (out_ch.led_green !== want.led_green)
                        flag_mismatch("led_green", {7'b0, out_ch.led_green},
                                      {7'b0, want.led_green});
                    frames_checked++;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                ready_next = 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0: ready_next = 1'b1;
                    1: ready_next = ($urandom_range(0, 1) == 0);
                    2: ready_next = ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        ready_next = 1'b1;
                        if ($urandom_range(0, 31) == 0)
                            stall_left = $urandom_range(20, 150);
                    end
                endcase
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(64, 512);
            end
            else
                mode_left--;
            out_ch.ready <= ready_next;
        end
    end

    initial
    begin : stimulus
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] addr_inv;
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] cmd_inv;
        logic [IV_W-1:0]   leader;
        logic [IV_W-1:0]   one;
        int                pick;

        in_ch.valid    = 1'b0;
        in_ch.interval = '0;
        out_ch.ready   = 1'b0;
        pred_state.leader_thr = LEADER_THRESHOLD_RST;
        pred_state.one_thr    = ONE_THRESHOLD_RST;
        pred_state.mode       = ST_IDLE;
        pred_state.bits_in    = '0;
        pred_state.word       = '0;
        pred_state.red        = 1'b1;
        pred_state.green      = 1'b1;
        gen_state = pred_state;

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset thresholds, boundary intervals, every button, LEDs kept.
        @(negedge clk);
        queue_interval('0);
        queue_interval(LEADER_THRESHOLD_RST);
        queue_frame({8'h00, 8'hFF, CMD_CH, ~CMD_CH}, 1'b1);
        queue_frame({8'hFF, 8'h00, CMD_NEXT, ~CMD_NEXT}, 1'b1);
        queue_frame({8'hA5, 8'h5A, CMD_PREV, ~CMD_PREV}, 1'b1);
        queue_broken(7, 1'b1);
        queue_frame({8'h3C, 8'h3C, 8'hFF, 8'h00}, 1'b1);
        queue_frame({8'h81, 8'h7E, CMD_CH_PLUS, CMD_CH_PLUS}, 1'b1);
        queue_frame({8'h5A, 8'hA5, CMD_CH_MINUS, ~CMD_CH_MINUS}, 1'b1);
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    leader = 16'd9000;
                    one    = 16'd1125;
                end
                1:
                begin
                    leader = '0;
                    one    = '0;
                end
                2:
                begin
                    leader = '1;
                    one    = '1;
                end
                3:
                begin
                    leader = 16'hFFFE;
                    one    = 16'hFFFE;
                end
                4:
                begin
                    leader = 16'd1;
                    one    = '1;
                end
                5:
                begin
                    leader = LEADER_THRESHOLD_RST;
                    one    = ONE_THRESHOLD_RST;
                end
                default:
                begin
                    leader = IV_W'($urandom_range(1000, 60000));
                    one    = IV_W'($urandom_range(0, int'(leader)));
                end
            endcase
            apply_thresholds(leader, one, p == 2 || p == 5);
            @(negedge clk);
            phase_used = 0;
            if (gen_state.leader_thr == '1)
            begin
                repeat (40)
                    queue_interval(IV_W'($urandom_range(0, 65535)));
            end
            else
            begin
                while (phase_used < PHASE_TARGET)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 75)
                    begin
                        case ($urandom_range(0, 7))
                            0:       cmd = CMD_CH_MINUS;
                            1:       cmd = CMD_CH;
                            2:       cmd = CMD_CH_PLUS;
                            3:       cmd = CMD_PREV;
                            4:       cmd = CMD_NEXT;
                            default: cmd = BYTE_W'($urandom_range(0, 255));
                        endcase
                        addr     = BYTE_W'($urandom_range(0, 255));
                        addr_inv = ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom) : ~addr;
                        cmd_inv  = ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom) : ~cmd;
                        queue_frame({addr, addr_inv, cmd, cmd_inv}, $urandom_range(0, 4) == 0);
                    end
                    else if (pick < 88)
                        queue_broken($urandom_range(0, 31), 1'($urandom_range(0, 1)));
                    else
                        repeat ($urandom_range(1, 4))
                            queue_interval(IV_W'($urandom_range(0, 65535)));
                end
            end
            drain();
        end

        $display("Covered %0d intervals over %0d threshold settings after the reset defaults;",
                 intervals_sent, settings_applied);
        $display("%0d decoded frames compared field by field, %0d mismatches.",
                 frames_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("ir_remote_frame_decoder test passed");
        else
            $display("ir_remote_frame_decoder test failed");
        $finish;
    end

endmodule
